### sv/cce_pkg.sv
// Package for the character-cell draw engine.
// Holds codes, widths, reset values, control/status structs and helpers.
// No dependencies.
package cce_pkg;

	localparam int DEF_MAX_COLS = 128;
	localparam int DEF_MAX_ROWS = 64;
	localparam int COLOR_BITS   = 4;

	// Signed working width for coordinates and clip bounds.
	localparam int CW = 13;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_COLS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLANK = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TRANS = 2'd3;

	localparam logic [7:0]            RST_COLS  = 8'd80;
	localparam logic [6:0]            RST_ROWS  = 7'd24;
	localparam logic [7:0]            RST_BLANK = 8'd32;
	localparam logic [COLOR_BITS-1:0] RST_TRANS = 4'd15;

	localparam logic [2:0] ACT_CLEAR = 3'd0;
	localparam logic [2:0] ACT_POINT = 3'd1;
	localparam logic [2:0] ACT_HLINE = 3'd2;
	localparam logic [2:0] ACT_VLINE = 3'd3;
	localparam logic [2:0] ACT_RECT  = 3'd4;
	localparam logic [2:0] ACT_READ  = 3'd5;

	typedef logic [COLOR_BITS-1:0] color_t;

	typedef struct packed {
		logic [2:0]         action;
		logic signed [11:0] row_a;
		logic signed [11:0] col_a;
		logic signed [11:0] row_b;
		logic signed [11:0] col_b;
		logic [7:0]         glyph;
		color_t             fore_color;
		color_t             fill_color;
		color_t             border_color;
	} cce_cmd_t;

	typedef struct packed {
		logic [7:0] cell_glyph;
		color_t     cell_fore;
		color_t     cell_back;
		logic       in_bounds;
	} cce_res_t;

	// Controller to datapath.
	typedef struct packed {
		logic load_cmd;
		logic setup;
		logic walk;
		logic load_res;
	} cce_ctl_t;

	// Datapath to controller.
	typedef struct packed {
		logic walk_go;
		logic walk_last;
	} cce_sts_t;

	function automatic logic signed [CW-1:0] smin(input logic signed [CW-1:0] a,
	                                               input logic signed [CW-1:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic signed [CW-1:0] smax(input logic signed [CW-1:0] a,
	                                               input logic signed [CW-1:0] b);
		return (a < b) ? b : a;
	endfunction

endpackage

### sv/cce_if.sv
// Valid/ready channel interfaces for commands and results.
// Depends on cce_pkg.
interface cce_cmd_if import cce_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [2:0]         action;
	logic signed [11:0] row_a;
	logic signed [11:0] col_a;
	logic signed [11:0] row_b;
	logic signed [11:0] col_b;
	logic [7:0]         glyph;
	color_t             fore_color;
	color_t             fill_color;
	color_t             border_color;

	modport source (output valid, action, row_a, col_a, row_b, col_b, glyph,
		fore_color, fill_color, border_color, input ready);
	modport sink (input valid, action, row_a, col_a, row_b, col_b, glyph,
		fore_color, fill_color, border_color, output ready);
endinterface

interface cce_res_if import cce_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] cell_glyph;
	color_t     cell_fore;
	color_t     cell_back;
	logic       in_bounds;

	modport source (output valid, cell_glyph, cell_fore, cell_back, in_bounds,
		input ready);
	modport sink (input valid, cell_glyph, cell_fore, cell_back, in_bounds,
		output ready);
endinterface

### sv/cce_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module cce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### sv/cce_ctrl.sv
// Sequencer for the draw engine: command accept, setup, cell walk, result hand-off.
// Depends on cce_pkg.
module cce_ctrl import cce_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output cce_ctl_t ctl,
	input  cce_sts_t sts
);
	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SETUP  = 2'd1;
	localparam logic [1:0] S_WALK   = 2'd2;
	localparam logic [1:0] S_FINISH = 2'd3;

	logic [1:0] state_q, state_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		ctl          = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.load_cmd = 1'b1;
					state_d      = S_SETUP;
				end
			end
			S_SETUP: begin
				ctl.setup = 1'b1;
				state_d   = sts.walk_go ? S_WALK : S_FINISH;
			end
			S_WALK: begin
				ctl.walk = 1'b1;
				if (sts.walk_last) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				// result slot must be free before the next result is loaded
				if (!out_valid_q || out_ready) begin
					ctl.load_res = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load_res) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

### sv/cce_datapath.sv
// Datapath: config registers, command registers, clip bounds, cell walk
// counters, the three cell stores and the result register.
// Depends on cce_pkg and cce_ram.
module cce_datapath import cce_pkg::*; #(
	parameter int MAX_COLS = DEF_MAX_COLS,
	parameter int MAX_ROWS = DEF_MAX_ROWS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  cce_cmd_t              cmd,
	input  cce_ctl_t              ctl,
	output cce_sts_t              sts,
	output cce_res_t              res
);
	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W = $clog2(DEPTH);

	localparam logic signed [CW-1:0] MAXR = CW'(MAX_ROWS);
	localparam logic signed [CW-1:0] MAXC = CW'(MAX_COLS);
	localparam logic signed [CW-1:0] ZERO = '0;
	localparam logic signed [CW-1:0] ONE  = CW'(1);

	// configuration
	logic [7:0] cols_q;
	logic [6:0] rows_q;
	logic [7:0] blank_q;
	color_t     trans_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q  <= RST_COLS;
			rows_q  <= RST_ROWS;
			blank_q <= RST_BLANK;
			trans_q <= RST_TRANS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COLS:  cols_q  <= cfg_data;
				REG_ROWS:  rows_q  <= cfg_data[6:0];
				REG_BLANK: blank_q <= cfg_data;
				REG_TRANS: trans_q <= cfg_data[COLOR_BITS-1:0];
				default: ;
			endcase
		end
	end

	// command register
	cce_cmd_t cmd_q;

	always_ff @(posedge clk) begin
		if (ctl.load_cmd) begin
			cmd_q <= cmd;
		end
	end

	logic signed [CW-1:0] ra, ca, rb, cb, nr, nc;
	assign ra = {cmd_q.row_a[11], cmd_q.row_a};
	assign ca = {cmd_q.col_a[11], cmd_q.col_a};
	assign rb = {cmd_q.row_b[11], cmd_q.row_b};
	assign cb = {cmd_q.col_b[11], cmd_q.col_b};

	// active size, saturated to the store size
	assign nr = (CW'(rows_q) > MAXR) ? MAXR : CW'(rows_q);
	assign nc = (CW'(cols_q) > MAXC) ? MAXC : CW'(cols_q);

	// raw region per action, then clip to the active screen
	logic signed [CW-1:0] rmin, rmax, cmin, cmax, r0, r1, c0, c1;
	logic                 is_draw;

	always_comb begin
		rmin    = ra;
		rmax    = ra;
		cmin    = ca;
		cmax    = ca;
		is_draw = 1'b1;
		unique case (cmd_q.action)
			ACT_CLEAR: begin
				rmin = ZERO;
				rmax = nr - ONE;
				cmin = ZERO;
				cmax = nc - ONE;
			end
			ACT_POINT: ;
			ACT_HLINE: begin
				cmin = smin(ca, cb);
				cmax = smax(ca, cb);
			end
			ACT_VLINE: begin
				rmin = smin(ra, rb);
				rmax = smax(ra, rb);
			end
			ACT_RECT: begin
				rmax = rb;
				cmax = cb;
			end
			default: is_draw = 1'b0;
		endcase
	end

	assign r0 = smax(rmin, ZERO);
	assign r1 = smin(rmax, nr - ONE);
	assign c0 = smax(cmin, ZERO);
	assign c1 = smin(cmax, nc - ONE);

	assign sts.walk_go = is_draw && (r0 <= r1) && (c0 <= c1);

	// walk counters
	logic [ROW_W-1:0] row_q, row_end_q;
	logic [COL_W-1:0] col_q, col_start_q, col_end_q;
	logic             col_wrap;

	assign col_wrap      = (col_q == col_end_q);
	assign sts.walk_last = col_wrap && (row_q == row_end_q);

	always_ff @(posedge clk) begin
		if (ctl.setup) begin
			row_q       <= r0[ROW_W-1:0];
			row_end_q   <= r1[ROW_W-1:0];
			col_q       <= c0[COL_W-1:0];
			col_start_q <= c0[COL_W-1:0];
			col_end_q   <= c1[COL_W-1:0];
		end else if (ctl.walk) begin
			if (col_wrap) begin
				col_q <= col_start_q;
				row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// per-cell write selection
	logic                  on_border, interior, is_clear, is_rect, fill_opaque;
	color_t                back_sel;
	logic [ADDR_W-1:0]     waddr, raddr;
	logic                  g_we, f_we, b_we;
	logic [7:0]            g_wd;
	color_t                f_wd, b_wd;

	assign is_clear    = (cmd_q.action == ACT_CLEAR);
	assign is_rect     = (cmd_q.action == ACT_RECT);
	assign fill_opaque = (cmd_q.fill_color != trans_q);
	assign on_border   = (CW'(row_q) == ra) || (CW'(row_q) == rb) ||
	                     (CW'(col_q) == ca) || (CW'(col_q) == cb);
	assign interior    = is_rect && !on_border;
	assign back_sel    = is_rect ? cmd_q.border_color : cmd_q.fill_color;

	always_comb begin
		if (is_clear) begin
			g_wd = blank_q;
			f_wd = trans_q;
			b_wd = trans_q;
			g_we = ctl.walk;
			f_we = ctl.walk;
			b_we = ctl.walk;
		end else if (interior) begin
			g_wd = blank_q;
			f_wd = cmd_q.fore_color;
			b_wd = cmd_q.fill_color;
			g_we = ctl.walk && fill_opaque;
			f_we = 1'b0;
			b_we = ctl.walk && fill_opaque;
		end else begin
			g_wd = cmd_q.glyph;
			f_wd = cmd_q.fore_color;
			b_wd = back_sel;
			g_we = ctl.walk;
			f_we = ctl.walk && (cmd_q.fore_color != trans_q);
			b_we = ctl.walk && (back_sel != trans_q);
		end
	end

	assign waddr = ADDR_W'(row_q) * ADDR_W'(MAX_COLS) + ADDR_W'(col_q);
	// read port always looks at cell (row_a, col_a); only used for reads in bounds
	assign raddr = ADDR_W'(cmd_q.row_a[ROW_W-1:0]) * ADDR_W'(MAX_COLS) +
	               ADDR_W'(cmd_q.col_a[COL_W-1:0]);

	logic [7:0] g_rd;
	color_t     f_rd, b_rd;

	cce_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_glyph_ram (
		.clk(clk), .we(g_we), .waddr(waddr), .wdata(g_wd), .raddr(raddr), .rdata(g_rd)
	);
	cce_ram #(.WIDTH(COLOR_BITS), .DEPTH(DEPTH)) u_fore_ram (
		.clk(clk), .we(f_we), .waddr(waddr), .wdata(f_wd), .raddr(raddr), .rdata(f_rd)
	);
	cce_ram #(.WIDTH(COLOR_BITS), .DEPTH(DEPTH)) u_back_ram (
		.clk(clk), .we(b_we), .waddr(waddr), .wdata(b_wd), .raddr(raddr), .rdata(b_rd)
	);

	// result register
	logic     hit;
	cce_res_t res_q;

	assign hit = (cmd_q.action == ACT_READ) && (ra >= ZERO) && (ca >= ZERO) &&
	             (ra < nr) && (ca < nc);

	always_ff @(posedge clk) begin
		if (ctl.load_res) begin
			if (hit) begin
				res_q <= '{cell_glyph: g_rd, cell_fore: f_rd, cell_back: b_rd,
				           in_bounds: 1'b1};
			end else begin
				res_q <= '0;
			end
		end
	end

	assign res = res_q;
endmodule

### sv/char_cell_draw_engine.sv
// Top level of the character-cell draw engine.
// Depends on cce_pkg, cce_if, cce_ctrl, cce_datapath (and cce_ram below it).
//
// Draws into a MAX_ROWS x MAX_COLS character store (glyph, foreground and
// background color per cell, addressed row * MAX_COLS + col). One command is
// in flight at a time, and each command yields exactly one result transfer;
// only an in-bounds read returns data, every other command answers all zeros.
// Steps per command: accept, setup, then a walk over the cells of the
// clipped region (clear: active rows x active columns; point: its own cell
// on screen, none off screen; line or rectangle: the clipped cells; read, empty
// region or unused action: none), then the result load. The walk is
// bound by the single write port of the cell stores, one cell per cycle. The
// next command is accepted while the previous result still waits in the
// output register; a new result is only loaded once that register has been
// emptied. The stores come up uninitialized: there is no clearing pass, so
// issue a clear before reading.
// Config writes (cfg_we/cfg_index/cfg_data) take effect at once and must only
// happen while no command is in flight.
module char_cell_draw_engine import cce_pkg::*; #(
	parameter int MAX_COLS = DEF_MAX_COLS,
	parameter int MAX_ROWS = DEF_MAX_ROWS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	cce_cmd_if.sink               cmd,
	cce_res_if.source             res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	cce_ctl_t ctl;
	cce_sts_t sts;
	cce_cmd_t cmd_item;
	cce_res_t res_item;

	// pack the incoming transfer for the datapath
	assign cmd_item = '{action: cmd.action, row_a: cmd.row_a, col_a: cmd.col_a,
	                    row_b: cmd.row_b, col_b: cmd.col_b, glyph: cmd.glyph,
	                    fore_color: cmd.fore_color, fill_color: cmd.fill_color,
	                    border_color: cmd.border_color};

	cce_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.ctl       (ctl),
		.sts       (sts)
	);

	cce_datapath #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_item),
		.ctl       (ctl),
		.sts       (sts),
		.res       (res_item)
	);

	// result register contents straight onto the channel
	assign res.cell_glyph = res_item.cell_glyph;
	assign res.cell_fore  = res_item.cell_fore;
	assign res.cell_back  = res_item.cell_back;
	assign res.in_bounds  = res_item.in_bounds;
endmodule

### sv/cce_checker.sv
// Port-level checker for the draw engine, bound to the top level.
// Depends on cce_pkg and cce_if.
module cce_checker import cce_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_valid,
	input logic       cmd_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] cell_glyph,
	input color_t     cell_fore,
	input color_t     cell_back,
	input logic       in_bounds
);
	// a stalled result holds its payload
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(cell_glyph) &&
		$stable(cell_fore) && $stable(cell_back) && $stable(in_bounds))
		else $error("result changed while stalled");

	// one command at a time: ready drops right after a transfer
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("second command taken while busy");

	// a new result is only loaded while a command is in flight
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> !$past(cmd_ready))
		else $error("result appeared with no command in flight");

	// out-of-bounds or non-read results carry zeros
	a_res_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !in_bounds |-> cell_glyph == 8'd0 && cell_fore == '0 &&
		cell_back == '0)
		else $error("non-read result not zero");
endmodule

bind char_cell_draw_engine cce_checker u_cce_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_valid  (cmd.valid),
	.cmd_ready  (cmd.ready),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.cell_glyph (res.cell_glyph),
	.cell_fore  (res.cell_fore),
	.cell_back  (res.cell_back),
	.in_bounds  (res.in_bounds)
);
